@@ rtl/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg: shared types for the keyed value table
// Request kinds, result status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Request kinds; the three remaining codes do nothing
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_LOOKUP = 3'd3,
    KIND_COUNT  = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    start;      // latch request, clear results and index
    logic    idx_inc;    // advance the walk index
    logic    rd_en;      // read the entry at the index
    logic    rd_next;    // read at index plus one instead
    logic    wr_en;      // write an entry
    logic    wr_shift;  // write read data at index, else append request
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    set_found;
    logic    set_value;  // capture read value as the lookup result
    logic    match_inc;
    logic    load_out;   // move results into the output register
  } kvt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] kind;
    logic       scan_end;   // index reached the entry count
    logic       shift_end;  // index is the last entry
    logic       full;
    logic       key_hit;    // read key equals request key
    logic       val_hit;    // read value equals request value
  } kvt_stat_t;

endpackage

@@ rtl/kvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// kvt_ctrl: controller of the keyed value table
// Sequences each request through search, compaction and result hand-off,
// and owns the input ready and output valid handshake signals.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kvt_pkg::kvt_stat_t stat,
  output kvt_pkg::kvt_cmd_t  cmd
);
  import kvt_pkg::*;

  state_t state, state_next;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        case (stat.kind)
          KIND_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_FINISH;
          end
          KIND_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_FINISH;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          KIND_ERASE, KIND_LOOKUP, KIND_COUNT: state_next = S_SCAN_RD;
          default: state_next = S_FINISH;
        endcase
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          // Walk finished without a key hit
          case (stat.kind)
            KIND_INSERT: begin
              cmd.wr_en   = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
            KIND_ERASE, KIND_LOOKUP: begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
            end
            default: ;
          endcase
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        case (stat.kind)
          KIND_COUNT: begin
            cmd.match_inc = stat.val_hit;
            cmd.idx_inc   = 1'b1;
            state_next    = S_SCAN_RD;
          end
          KIND_INSERT: begin
            if (stat.key_hit) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DUPLICATE;
              state_next     = S_FINISH;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
          KIND_LOOKUP: begin
            if (stat.key_hit) begin
              cmd.set_found = 1'b1;
              cmd.set_value = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
          KIND_ERASE: begin
            if (stat.key_hit) begin
              cmd.set_found = 1'b1;
              state_next    = S_SHIFT_RD;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      // Compaction: move each later entry down one place
      S_SHIFT_RD: begin
        if (stat.shift_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/kvt_datapath.sv @@
// ----------------------------------------------------------------------------
// kvt_datapath: storage and compare logic of the keyed value table
// Key and value memories, entry count, walk index, request latch, result
// accumulation and the output register.
// ----------------------------------------------------------------------------
module kvt_datapath #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         kind,
  input  logic [31:0]        key,
  input  logic [31:0]        value,
  input  kvt_pkg::kvt_cmd_t  cmd,
  output kvt_pkg::kvt_stat_t stat,
  output logic [1:0]         status,
  output logic               found,
  output logic [31:0]        value_out,
  output logic [5:0]         match_count,
  output logic [5:0]         occupancy
);
  import kvt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_BITS-1:0]   mem_key [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] mem_val [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  logic [2:0]            kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         idx_plus;
  logic [CW:0]           idx_plus_w;
  logic [CW-1:0]         match_total;
  status_t               res_status;
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_value;

  logic [KEY_BITS+31:0]   key_ext;
  logic [VALUE_BITS+31:0] val_ext;
  logic [VALUE_BITS+31:0] res_val_ext;
  logic [CW+5:0]          cnt_ext;
  logic [CW+5:0]          match_ext;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [KEY_BITS-1:0]    wr_key;
  logic [VALUE_BITS-1:0]  wr_val;

  // Width fitting of ports to the stored widths
  assign key_ext     = {{KEY_BITS{1'b0}}, key};
  assign val_ext     = {{VALUE_BITS{1'b0}}, value};
  assign res_val_ext = {32'd0, res_value};
  assign cnt_ext     = {6'd0, count};
  assign match_ext   = {6'd0, match_total};

  // Addresses and write data
  assign idx_plus_w = {1'b0, idx} + {{CW{1'b0}}, 1'b1};
  assign idx_plus   = idx_plus_w[CW-1:0];
  assign rd_addr    = cmd.rd_next ? idx_plus[AW-1:0] : idx[AW-1:0];
  assign wr_addr    = cmd.wr_shift ? idx[AW-1:0] : count[AW-1:0];
  assign wr_key     = cmd.wr_shift ? rd_key : key_q;
  assign wr_val     = cmd.wr_shift ? rd_val : val_q;

  // Entry memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_val[wr_addr] <= wr_val;
    end
    if (cmd.rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_val <= mem_val[rd_addr];
    end
  end

  // Status toward the controller
  always_comb begin
    stat.kind      = kind_q;
    stat.scan_end  = (idx == count);
    stat.shift_end = (idx_plus_w >= {1'b0, count});
    stat.full      = (count == CW'(TABLE_DEPTH));
    stat.key_hit   = (rd_key == key_q);
    stat.val_hit   = (rd_val == val_q);
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // Request latch, walk index and result accumulation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q      <= kind;
      key_q       <= key_ext[KEY_BITS-1:0];
      val_q       <= val_ext[VALUE_BITS-1:0];
      idx         <= '0;
      match_total <= '0;
      res_status  <= ST_OK;
      res_found   <= 1'b0;
      res_value   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx_plus;
      end
      if (cmd.match_inc) begin
        match_total <= match_total + CW'(1);
      end
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
      if (cmd.set_found) begin
        res_found <= 1'b1;
      end
      if (cmd.set_value) begin
        res_value <= rd_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      found       <= res_found;
      value_out   <= res_val_ext[31:0];
      match_count <= match_ext[5:0];
      occupancy   <= cnt_ext[5:0];
    end
  end

endmodule

@@ rtl/keyed_value_table_top.sv @@
// ----------------------------------------------------------------------------
// keyed_value_table_top: associative key/value table
// Packed, insertion-ordered table of unique keys with clear, insert, erase,
// lookup and count-by-value requests, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table sits in a single-port-read key
// and value memory, walked one entry at a time (read, then compare). Clear,
// unused kinds and an insert into a full table go straight to the result;
// an insert, erase or lookup walk stops on a key hit, and otherwise a walk
// covers all held entries. Erase walks to the hit and then moves each later
// entry down one place. A finished result sits in an output register, and
// the next request is accepted while it waits; that request's result then
// holds in its last state until the first one is taken. Entries need no
// clearing after reset.
module keyed_value_table_top #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] value_out,
  output logic [5:0]  match_count,
  output logic [5:0]  occupancy
);
  import kvt_pkg::*;

  kvt_cmd_t  cmd;
  kvt_stat_t stat;

  // Sequencer
  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and compares
  kvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .found       (found),
    .value_out   (value_out),
    .match_count (match_count),
    .occupancy   (occupancy)
  );

endmodule
